// ===== hdl/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg
// shared constants, types and command/status structs of the cache unit
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

    localparam int WAYS         = 4;
    localparam int LINE_BYTES   = 32;
    localparam int CACHE_BYTES  = 4096;
    localparam int MEMORY_BYTES = 65536;

    localparam int SETS   = CACHE_BYTES / WAYS / LINE_BYTES;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MEM_W  = $clog2(MEMORY_BYTES);
    localparam int TAG_W  = MEM_W - OFF_W - SET_W;
    localparam int IDX_W  = OFF_W + 1;
    localparam int LMEM_W = WAY_W + SET_W + OFF_W;
    localparam int ADDR_W = 17;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_ACCESS,
        ST_RESPOND
    } state_t;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_WB,
        MOP_FILL
    } mop_t;

    typedef struct packed {
        logic             latch;
        logic             lookup;
        mop_t             mop;
        logic [OFF_W-1:0] idx;
        logic             access;
        logic             clear_wr;
        logic [MEM_W-1:0] clear_addr;
        logic             respond;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic hit;
        logic dirty_victim;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/swc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swc_ctrl
// sequencer: clear pass, lookup, write-back, fill, access and respond
// ----------------------------------------------------------------------------
`default_nettype none

module swc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    input  swc_pkg::sts_t      sts,
    output swc_pkg::cmd_t      cmd
);
    import swc_pkg::*;

    state_t           state_reg, state_next;
    logic [MEM_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             idx_last;

    assign idx_last = (idx_reg == IDX_W'(LINE_BYTES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {MEM_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                priority if (sts.bad)
                    state_next = ST_RESPOND;
                else if (sts.hit)
                    state_next = ST_ACCESS;
                else if (sts.dirty_victim)
                    state_next = ST_WB;
                else
                    state_next = ST_FILL;
            end
            ST_WB:
            begin
                if (idx_last)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (idx_last)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:  state_next = ST_RESPOND;
            ST_RESPOND: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.mop        = MOP_NONE;
        cmd.idx        = idx_reg[OFF_W-1:0];
        cmd.clear_addr = clr_reg;
        clr_next       = clr_reg;
        idx_next       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                clr_next     = clr_reg + MEM_W'(1);
            end
            ST_IDLE:    cmd.latch  = start;
            ST_LOOKUP:  cmd.lookup = 1'b1;
            ST_WB, ST_FILL:
            begin
                if (!idx_last)
                begin
                    cmd.mop  = (state_reg == ST_WB) ? MOP_WB : MOP_FILL;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_ACCESS:  cmd.access  = 1'b1;
            ST_RESPOND: cmd.respond = 1'b1;
            default:    cmd.latch   = 1'b0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESPOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
        end
    end

    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    a_respond_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(LINE_BYTES))
        else $error("line byte index overran the line");

endmodule

`default_nettype wire

// ===== hdl/swc_dp.sv =====
// ----------------------------------------------------------------------------
// swc_dp
// tag, lru and data stores, backing memory, counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module swc_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  swc_pkg::cmd_t                      cmd,
    output swc_pkg::sts_t                      sts,
    input  wire logic                          operation,
    input  wire logic [swc_pkg::ADDR_W-1:0]    address,
    input  wire logic [swc_pkg::DATA_W-1:0]    write_data,
    output logic      [swc_pkg::DATA_W-1:0]    read_data,
    output logic                               hit,
    output logic                               bad_address,
    output logic      [swc_pkg::CNT_W-1:0]     accesses_total,
    output logic      [swc_pkg::CNT_W-1:0]     misses_total
);
    import swc_pkg::*;

    localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(WAYS - 1);

    // request registers
    logic              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    // line state
    logic [WAYS-1:0]  valid_reg [SETS];
    logic [WAYS-1:0]  dirty_reg [SETS];
    logic [WAY_W-1:0] rank_reg  [SETS][WAYS];
    logic [TAG_W-1:0] tag_reg   [SETS][WAYS];

    // memories
    logic [DATA_W-1:0] line_mem [2**LMEM_W];
    logic [DATA_W-1:0] back_mem [2**MEM_W];
    logic [DATA_W-1:0] lb_q;
    logic [DATA_W-1:0] bm_q;
    mop_t              mop_d_reg;
    logic [OFF_W-1:0]  idx_d_reg;

    logic [WAY_W-1:0] way_reg;
    logic [TAG_W-1:0] vtag_reg;
    logic             hit_reg;
    logic             bad_reg;
    logic [CNT_W-1:0] acc_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;

    logic [OFF_W-1:0] off;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic             bad_c;
    logic             hit_c;
    logic             found_c;
    logic [WAY_W-1:0] hway_c;
    logic [WAY_W-1:0] vway_c;
    logic [WAY_W-1:0] way_c;
    logic [WAY_W-1:0] old_c;
    logic [WAY_W-1:0] rank_new [WAYS];

    assign off     = addr_reg[OFF_W-1:0];
    assign set_idx = addr_reg[OFF_W +: SET_W];
    assign tag     = addr_reg[OFF_W+SET_W +: TAG_W];
    assign bad_c   = (addr_reg >= ADDR_W'(MEMORY_BYTES));

    // hit search, victim choice and lru update
    always_comb
    begin
        hit_c   = 1'b0;
        hway_c  = '0;
        found_c = 1'b0;
        vway_c  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_c && valid_reg[set_idx][w] && tag_reg[set_idx][w] == tag)
            begin
                hit_c  = 1'b1;
                hway_c = WAY_W'(w);
            end
            if (!found_c)
            begin
                if (!valid_reg[set_idx][w])
                begin
                    found_c = 1'b1;
                    vway_c  = WAY_W'(w);
                end
                else if (rank_reg[set_idx][w] > rank_reg[set_idx][vway_c])
                    vway_c = WAY_W'(w);
            end
        end
        way_c = hit_c ? hway_c : vway_c;
        old_c = hit_c ? rank_reg[set_idx][way_c] : RANK_MAX;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == way_c)
                rank_new[w] = '0;
            else if (valid_reg[set_idx][w] && rank_reg[set_idx][w] < old_c &&
                     rank_reg[set_idx][w] < RANK_MAX)
                rank_new[w] = rank_reg[set_idx][w] + WAY_W'(1);
            else
                rank_new[w] = rank_reg[set_idx][w];
        end
    end

    assign sts.bad          = bad_c;
    assign sts.hit          = hit_c;
    assign sts.dirty_victim = valid_reg[set_idx][vway_c] && dirty_reg[set_idx][vway_c];

    // request capture, lookup way and victim tag capture and tag update, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= operation;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.lookup && !bad_c)
        begin
            way_reg  <= way_c;
            vtag_reg <= tag_reg[set_idx][vway_c];
            if (!hit_c)
                tag_reg[set_idx][vway_c] <= tag;
        end
    end

    // line state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
                for (int w = 0; w < WAYS; w++)
                    rank_reg[s][w] <= '0;
            end
            hit_reg      <= 1'b0;
            bad_reg      <= 1'b0;
            acc_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            mop_d_reg    <= MOP_NONE;
        end
        else
        begin
            mop_d_reg <= cmd.mop;
            if (cmd.lookup)
            begin
                bad_reg <= bad_c;
                hit_reg <= !bad_c && hit_c;
                if (!bad_c)
                begin
                    if (acc_cnt_reg != {CNT_W{1'b1}})
                        acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
                    for (int w = 0; w < WAYS; w++)
                        rank_reg[set_idx][w] <= rank_new[w];
                    if (!hit_c)
                    begin
                        if (miss_cnt_reg != {CNT_W{1'b1}})
                            miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                        valid_reg[set_idx][vway_c] <= 1'b1;
                        dirty_reg[set_idx][vway_c] <= 1'b0;
                    end
                end
            end
            if (cmd.access && op_reg)
                dirty_reg[set_idx][way_reg] <= 1'b1;
        end
    end

    // line data memory: one read, one write port
    always_ff @(posedge clk)
    begin
        idx_d_reg <= cmd.idx;
        if (cmd.mop == MOP_WB)
            lb_q <= line_mem[{way_reg, set_idx, cmd.idx}];
        else if (cmd.access)
            lb_q <= line_mem[{way_reg, set_idx, off}];
        if (mop_d_reg == MOP_FILL)
            line_mem[{way_reg, set_idx, idx_d_reg}] <= bm_q;
        else if (cmd.access && op_reg)
            line_mem[{way_reg, set_idx, off}] <= wdata_reg;
    end

    // backing memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.mop == MOP_FILL)
            bm_q <= back_mem[{tag, set_idx, cmd.idx}];
        if (cmd.clear_wr)
            back_mem[cmd.clear_addr] <= '0;
        else if (mop_d_reg == MOP_WB)
            back_mem[{vtag_reg, set_idx, idx_d_reg}] <= lb_q;
    end

    assign read_data      = (bad_reg) ? '0 : (op_reg ? wdata_reg : lb_q);
    assign hit            = hit_reg;
    assign bad_address    = bad_reg;
    assign accesses_total = acc_cnt_reg;
    assign misses_total   = miss_cnt_reg;

    a_miss_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
        miss_cnt_reg <= acc_cnt_reg)
        else $error("miss count above access count");

    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lookup && !bad_c && !hit_c) |=> valid_reg[set_idx][way_reg])
        else $error("filled way not marked valid");

    a_mru_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lookup && !bad_c) |=> (rank_reg[set_idx][way_reg] == '0))
        else $error("accessed way not made most recent");

endmodule

`default_nettype wire

// ===== hdl/set_assoc_writeback_cache_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_unit
// 4-way write-back, write-allocate byte cache with true lru over a 64 KiB store
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. After reset the unit zeroes every byte of the backing
// store (busy high) before it takes its first request. A hit passes through
// lookup, access and respond after the accept cycle, and an out-of-range
// address through lookup and respond; a miss into a clean or empty way adds
// the one-byte-per-cycle line fill before the access, and a dirty victim
// adds the write-back of the old line before the fill. The byte-at-a-time
// fill and write-back follow from the single byte ports of the line data
// memory and of the backing store.
`default_nettype none

module set_assoc_writeback_cache_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [swc_pkg::ADDR_W-1:0]    address,
    input  wire logic [swc_pkg::DATA_W-1:0]    write_data,
    output logic                               done,
    output logic      [swc_pkg::DATA_W-1:0]    read_data,
    output logic                               hit,
    output logic                               bad_address,
    output logic      [swc_pkg::CNT_W-1:0]     accesses_total,
    output logic      [swc_pkg::CNT_W-1:0]     misses_total
);
    import swc_pkg::*;

    // controller drives the datapath through one command word
    cmd_t cmd;
    // lookup outcome back to the controller
    sts_t sts;

    swc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    swc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (operation),
        .address        (address),
        .write_data     (write_data),
        .read_data      (read_data),
        .hit            (hit),
        .bad_address    (bad_address),
        .accesses_total (accesses_total),
        .misses_total   (misses_total)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the set-associative write-back cache unit: random
// and directed byte reads/writes against a behavioral cache predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swc_pkg::*;

    localparam int N_SETS  = CACHE_BYTES / WAYS / LINE_BYTES;
    localparam int N_LINES = WAYS * N_SETS;

    // request to the unit
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } request_t;

    // expected response fields
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              hit;
        logic              bad;
        logic [CNT_W-1:0]  acc;
        logic [CNT_W-1:0]  miss;
    } response_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              bad_address;
    logic [CNT_W-1:0]  accesses_total;
    logic [CNT_W-1:0]  misses_total;

    set_assoc_writeback_cache_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .address(address), .write_data(write_data),
        .done(done), .read_data(read_data), .hit(hit), .bad_address(bad_address),
        .accesses_total(accesses_total), .misses_total(misses_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor state: its own copy of tags, lru ranks, lines and memory
    // ------------------------------------------------------------------
    logic [7:0]        p_tag   [N_LINES];
    logic              p_valid [N_LINES];
    logic              p_dirty [N_LINES];
    int unsigned       p_rank  [N_LINES];
    logic [DATA_W-1:0] p_line  [N_LINES * LINE_BYTES];
    logic [DATA_W-1:0] p_mem   [MEMORY_BYTES];
    logic [CNT_W-1:0]  p_acc;
    logic [CNT_W-1:0]  p_miss;

    function automatic int line_of(int way, int set);
        return (way * N_SETS + set) % N_LINES;
    endfunction

    // most recent goes to rank 0, younger valid ways age by one
    function automatic void refresh_lru(int set, int way, int unsigned old);
        for (int w = 0; w < WAYS; w++)
        begin
            int s;
            s = line_of(w, set);
            if (w != way && p_valid[s] && p_rank[s] < old && p_rank[s] < WAYS - 1)
                p_rank[s]++;
        end
        p_rank[line_of(way, set)] = 0;
    endfunction

    function automatic response_t cache_access(request_t rq);
        response_t r;
        int off, set, tag, way, s, vic_base, base;
        logic found;
        r = '0;
        if (rq.addr >= MEMORY_BYTES)
        begin
            r.bad  = 1'b1;
            r.acc  = p_acc;
            r.miss = p_miss;
            return r;
        end
        off = rq.addr % LINE_BYTES;
        set = (rq.addr / LINE_BYTES) % N_SETS;
        tag = (rq.addr / LINE_BYTES / N_SETS) & 8'hFF;
        if (p_acc != '1) p_acc++;
        found = 1'b0;
        way = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            s = line_of(w, set);
            if (!found && p_valid[s] && p_tag[s] == tag)
            begin
                found = 1'b1;
                way = w;
            end
        end
        if (found)
            refresh_lru(set, way, p_rank[line_of(way, set)]);
        else
        begin
            if (p_miss != '1) p_miss++;
            // victim: first invalid way, else oldest rank, lowest way on ties
            way = -1;
            for (int w = 0; w < WAYS; w++)
                if (way < 0 && !p_valid[line_of(w, set)]) way = w;
            if (way < 0)
            begin
                way = 0;
                for (int w = 1; w < WAYS; w++)
                    if (p_rank[line_of(w, set)] > p_rank[line_of(way, set)]) way = w;
            end
            s = line_of(way, set);
            if (p_valid[s] && p_dirty[s])
            begin
                vic_base = (p_tag[s] * N_SETS + set) * LINE_BYTES;
                for (int i = 0; i < LINE_BYTES; i++)
                    p_mem[(vic_base + i) % MEMORY_BYTES] = p_line[s * LINE_BYTES + i];
            end
            base = rq.addr - off;
            for (int i = 0; i < LINE_BYTES; i++)
                p_line[s * LINE_BYTES + i] = p_mem[(base + i) % MEMORY_BYTES];
            p_tag[s]   = tag[7:0];
            p_valid[s] = 1'b1;
            p_dirty[s] = 1'b0;
            refresh_lru(set, way, WAYS - 1);
        end
        s = line_of(way, set);
        if (rq.op == OP_WRITE)
        begin
            p_line[s * LINE_BYTES + off] = rq.wdata;
            p_dirty[s] = 1'b1;
            r.rdata = rq.wdata;
        end
        else
            r.rdata = p_line[s * LINE_BYTES + off];
        r.hit  = found;
        r.acc  = p_acc;
        r.miss = p_miss;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: pops pending requests, idles at random per phase
    // ------------------------------------------------------------------
    request_t    pending_reqs[$];
    response_t   expected_resps[$];
    int unsigned send_idle_pct;
    logic        hold_sender;
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_hits;
    int unsigned n_bad;
    int unsigned n_errors;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            operation  <= 1'b0;
            address    <= '0;
            write_data <= '0;
        end
        else
        begin
            request_t nxt;
            logic     take;
            // request handed over on this edge
            take = start && !busy;
            if (take)
            begin
                expected_resps.push_back(cache_access('{operation, address, write_data}));
                n_accepted++;
            end
            if (!start || take)
            begin
                if (pending_reqs.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    start      <= 1'b1;
                    operation  <= nxt.op;
                    address    <= nxt.addr;
                    write_data <= nxt.wdata;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done pulse is checked against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            response_t want;
            if (expected_resps.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected response at %0t", $realtime);
            end
            else
            begin
                want = expected_resps.pop_front();
                n_checked++;
                if (hit) n_hits++;
                if (bad_address) n_bad++;
                if (want.rdata !== read_data || want.hit !== hit ||
                    want.bad !== bad_address || want.acc !== accesses_total ||
                    want.miss !== misses_total)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at %0t: exp data %h hit %b bad %b acc %0d miss %0d,",
                                 $realtime, want.rdata, want.hit, want.bad, want.acc,
                                 want.miss, " got data %h hit %b bad %b acc %0d miss %0d",
                                 read_data, hit, bad_address, accesses_total, misses_total);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void queue_req(logic op, int unsigned addr, int unsigned wd);
        request_t rq;
        rq.op    = op;
        rq.addr  = addr[ADDR_W-1:0];
        rq.wdata = wd[DATA_W-1:0];
        pending_reqs.push_back(rq);
    endfunction

    // address mostly drawn from a small working set so that sets thrash
    // and dirty victims get written back and read again
    function automatic int unsigned pick_addr();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return $urandom_range(131071, MEMORY_BYTES);
        if (sel < 70)
            return ($urandom_range(7) * N_SETS + $urandom_range(3)) * LINE_BYTES +
                   $urandom_range(LINE_BYTES - 1);
        return $urandom_range(MEMORY_BYTES - 1);
    endfunction

    // checked away from the driving edge so queue and start agree
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_resps.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < N_LINES; i++)
        begin
            p_valid[i] = 1'b0;
            p_dirty[i] = 1'b0;
            p_rank[i]  = 0;
            p_tag[i]   = '0;
        end
        for (int i = 0; i < N_LINES * LINE_BYTES; i++) p_line[i] = '0;
        for (int i = 0; i < MEMORY_BYTES; i++) p_mem[i] = '0;
        p_acc = '0;
        p_miss = '0;
        send_idle_pct = 0;
        hold_sender = 1'b0;
        n_accepted = 0;
        n_checked = 0;
        n_hits = 0;
        n_bad = 0;
        n_errors = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: read of reset memory, write/read, extremes, out of range
        queue_req(OP_READ, 0, 0);
        queue_req(OP_WRITE, 0, 8'hFF);
        queue_req(OP_READ, 0, 0);
        queue_req(OP_WRITE, MEMORY_BYTES - 1, 8'h00);
        queue_req(OP_WRITE, MEMORY_BYTES - 1, 8'hA5);
        queue_req(OP_READ, MEMORY_BYTES - 1, 8'hFF);
        queue_req(OP_READ, MEMORY_BYTES, 8'h5A);
        queue_req(OP_WRITE, 131071, 8'hFF);
        queue_req(OP_WRITE, 65536 + 21845, 8'h55);
        // five dirty lines in set 0: fills invalid ways, then evicts lru
        for (int t = 1; t <= 5; t++)
            queue_req(OP_WRITE, t * N_SETS * LINE_BYTES + 31, t);
        // touch way holding tag 2 so it stops being oldest, then evict
        queue_req(OP_READ, 2 * N_SETS * LINE_BYTES + 31, 0);
        queue_req(OP_READ, 6 * N_SETS * LINE_BYTES, 0);
        // read back the evicted dirty lines from memory
        queue_req(OP_READ, 1 * N_SETS * LINE_BYTES + 31, 0);
        queue_req(OP_READ, 0, 0);
        queue_req(OP_READ, 3 * N_SETS * LINE_BYTES + 31, 0);
        drain();

        // random phases: none, sender idle, then a paused drain, then mixed
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 23 : 0;
            for (int i = 0; i < 360; i++)
                queue_req(1'($urandom_range(1)), pick_addr(), $urandom_range(255));
            if (ph == 2)
            begin
                // sender holds off until every outstanding response is back
                while (pending_reqs.size() > 180) @(negedge clk);
                hold_sender = 1'b1;
                while (start || expected_resps.size() > 0) @(negedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        repeat (20) @(posedge clk);

        $display("ran %0d requests, %0d responses checked (%0d hits, %0d bad address)",
                 n_accepted, n_checked, n_hits, n_bad);
        if (n_errors == 0 && expected_resps.size() == 0)
            $display("PASS set_assoc_writeback_cache_unit");
        else
        begin
            $display("%0d errors, %0d responses missing", n_errors, expected_resps.size());
            $display("FAIL set_assoc_writeback_cache_unit");
        end
        $finish;
    end

    // worst case: clearing pass plus ~1450 requests with gaps
    initial
    begin
        #20ms;
        $display("timeout");
        $display("FAIL set_assoc_writeback_cache_unit");
        $finish;
    end

endmodule

`default_nettype wire

// ===== set_assoc_writeback_cache_unit.f =====
hdl/swc_pkg.sv
hdl/swc_ctrl.sv
hdl/swc_dp.sv
hdl/set_assoc_writeback_cache_unit.sv
dv/tb_top.sv
